// ===== rtl/core/grl_pkg.sv =====
`timescale 1ns / 1ps

package grl_pkg;

	localparam int CFG_W      = 11;
	localparam int IDX_W      = 10;
	localparam int DATA_W     = 32;
	localparam int FIELDS     = 4;
	localparam int RADIX_BITS = 4;

	localparam logic [1:0] STATUS_STORED   = 2'd0;
	localparam logic [1:0] STATUS_COMPUTED = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	localparam logic REG_SOURCE_POINTS = 1'b0;
	localparam logic REG_TARGET_POINTS = 1'b1;

	localparam logic ACT_STORE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_MUL,
		ST_P_DIV,
		ST_P_WAIT,
		ST_Q_MUL,
		ST_Q_DIV,
		ST_Q_WAIT,
		ST_R_MUL,
		ST_R_DIV,
		ST_R_WAIT,
		ST_WEIGHT,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_F_MUL0,
		ST_F_MUL1,
		ST_F_ADD,
		ST_F_ABS,
		ST_F_DIV,
		ST_F_WAIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [CFG_W-1:0]  rem_init;
		logic [DATA_W-1:0] dividend;
		logic [CFG_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/grl_ram.sv =====
`timescale 1ns / 1ps

module grl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/grl_div.sv =====
`timescale 1ns / 1ps

module grl_div (
	input  logic              clk,
	input  logic              arst_n,
	input  grl_pkg::div_req_t req,
	output grl_pkg::div_rsp_t rsp
);

	localparam int CW    = grl_pkg::CFG_W;
	localparam int DW    = grl_pkg::DATA_W;
	localparam int RB    = grl_pkg::RADIX_BITS;
	localparam int STEPS = grl_pkg::DATA_W / grl_pkg::RADIX_BITS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [CW-1:0]    rem_q;
	logic [DW-1:0]    bits_q;
	logic [CW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    rem_nx;
	logic [DW-1:0]    bits_nx;

	// RB restoring steps per cycle while busy; remainder always stays below the divisor
	always_comb begin
		logic [CW:0] cand;
		logic        qbit;
		rem_nx  = rem_q;
		bits_nx = bits_q;
		for (int k = 0; k < RB; k++) begin
			cand = {rem_nx, bits_nx[DW-1]};
			qbit = (cand >= {1'b0, dvs_q});
			if (qbit) begin
				cand = cand - {1'b0, dvs_q};
			end
			rem_nx  = cand[CW-1:0];
			bits_nx = {bits_nx[DW-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			bits_q <= req.dividend;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			bits_q <= bits_nx;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = bits_q;

endmodule

// ===== rtl/core/grid_resample_linear_core.sv =====
`timescale 1ns / 1ps

// Resamples four Q16.16 fields from a source grid to a target grid. A store
// transaction (action 0) writes one source point and answers in the next cycle
// with busy staying low, so stores may follow each other every cycle; an index
// out of range answers the same way. A compute transaction (action 1) raises
// busy and runs through one shared multiplier and one shared divider that
// retires four quotient bits per cycle while it runs. The result for the
// target's last point is read straight from the source store; a picked point
// (target no larger than source) takes one index division first, and an
// interpolated point takes three index divisions and then one
// multiply-multiply-add-divide pass per field. Busy drops in the result
// cycle. The result is shown on the output ports for one cycle with done high
// and cannot be held off, so the receiver must take it then.
// Registers source_points (0x0) and target_points (0x4) are clamped to
// [2, MAX_POINTS] and must be written only while busy is low and no result is
// pending. The source store has no reset; read only points already stored.
module grid_resample_linear_core #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic [grl_pkg::IDX_W-1:0]          point_index,
	input  logic signed [grl_pkg::DATA_W-1:0]  in_a,
	input  logic signed [grl_pkg::DATA_W-1:0]  in_delta,
	input  logic signed [grl_pkg::DATA_W-1:0]  in_phi,
	input  logic signed [grl_pkg::DATA_W-1:0]  in_pi,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [grl_pkg::DATA_W-1:0]  out_a,
	output logic signed [grl_pkg::DATA_W-1:0]  out_delta,
	output logic signed [grl_pkg::DATA_W-1:0]  out_phi,
	output logic signed [grl_pkg::DATA_W-1:0]  out_pi
);

	localparam int CW     = grl_pkg::CFG_W;
	localparam int IW     = grl_pkg::IDX_W;
	localparam int DW     = grl_pkg::DATA_W;
	localparam int NF     = grl_pkg::FIELDS;
	localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PROD_W = DW + CW + 2;
	localparam int MAG_W  = PROD_W - 1;
	localparam int HI_INT = (MAX_POINTS > (1 << CW) - 1) ? (1 << CW) - 1 : MAX_POINTS;
	localparam logic [CW-1:0] CLAMP_HI = CW'(HI_INT);
	localparam logic [CW-1:0] CLAMP_LO = CW'(2);

	// configuration
	logic [CW-1:0] src_q;
	logic [CW-1:0] tgt_q;
	logic [CW-1:0] s_cl;
	logic [CW-1:0] t_cl;
	logic [CW-1:0] sm1;
	logic [CW-1:0] tm1;
	logic          cfg_wr;

	// sequencer and datapath
	grl_pkg::state_t   state_q;
	grl_pkg::state_t   state_nx;
	grl_pkg::div_req_t div_req;
	grl_pkg::div_rsp_t div_rsp;

	logic                          accept;
	logic                          idx_ok_store;
	logic                          idx_ok_comp;
	logic                          idx_last;
	logic [IW-1:0]                 idx_q;
	logic                          pick_q;
	logic [CW-1:0]                 p_q;
	logic [CW-1:0]                 qi_q;
	logic [CW-1:0]                 ri_q;
	logic signed [CW:0]            wa_q;
	logic signed [CW:0]            wb_q;
	logic [CW-1:0]                 c_q;
	logic [1:0]                    f_q;
	logic [NF-1:0][DW-1:0]         v0_q;
	logic [NF-1:0][DW-1:0]         v1_q;
	logic signed [DW:0]            mul_a;
	logic signed [CW:0]            mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      mul_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic signed [PROD_W-1:0]      num_q;
	logic [MAG_W-1:0]              mag_q;
	logic                          neg_q;
	logic                          done_q;
	logic [1:0]                    status_q;
	logic [NF-1:0][DW-1:0]         res_q;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 ram_raddr;
	logic [NF*DW-1:0]              ram_wdata;
	logic [NF*DW-1:0]              ram_rdata;
	logic [AW+IW-1:0]              waddr_ext;
	logic [AW+CW-1:0]              p_ext;
	logic [AW+CW-1:0]              p1_ext;
	logic signed [CW:0]            c_raw;
	logic [DW-1:0]                 quot_s;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= CW'(2);
			tgt_q <= CW'(1024);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				grl_pkg::REG_SOURCE_POINTS: src_q <= pwdata[CW-1:0];
				grl_pkg::REG_TARGET_POINTS: tgt_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			grl_pkg::REG_SOURCE_POINTS: prdata = {{(32-CW){1'b0}}, src_q};
			grl_pkg::REG_TARGET_POINTS: prdata = {{(32-CW){1'b0}}, tgt_q};
			default:                    prdata = '0;
		endcase
	end

	assign s_cl = (src_q < CLAMP_LO) ? CLAMP_LO : ((src_q > CLAMP_HI) ? CLAMP_HI : src_q);
	assign t_cl = (tgt_q < CLAMP_LO) ? CLAMP_LO : ((tgt_q > CLAMP_HI) ? CLAMP_HI : tgt_q);
	assign sm1  = s_cl - CW'(1);
	assign tm1  = t_cl - CW'(1);

	assign busy         = (state_q != grl_pkg::ST_IDLE);
	assign accept       = start && !busy;
	assign idx_ok_store = ({1'b0, point_index} < s_cl);
	assign idx_ok_comp  = ({1'b0, point_index} < t_cl);
	assign idx_last     = ({1'b0, point_index} == tm1);

	// memory: all four fields of a point in one word
	assign waddr_ext = {{AW{1'b0}}, point_index};
	assign ram_waddr = waddr_ext[AW-1:0];
	assign ram_wdata = {in_pi, in_phi, in_delta, in_a};
	assign ram_we    = accept && (action == grl_pkg::ACT_STORE) && idx_ok_store;
	assign p_ext     = {{AW{1'b0}}, p_q};
	assign p1_ext    = {{AW{1'b0}}, p_q + CW'(1)};

	grl_ram #(
		.WIDTH(NF * DW),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	grl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign prod   = mul_a * mul_b;
	assign c_raw  = $signed({1'b0, ri_q}) - $signed({1'b0, qi_q});
	assign quot_s = neg_q ? (DW'(0) - div_rsp.quotient) : div_rsp.quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx         = state_q;
		div_req          = '0;
		mul_a            = '0;
		mul_b            = '0;
		ram_raddr        = p_ext[AW-1:0];
		unique case (state_q)
			grl_pkg::ST_IDLE: begin
				if (accept && (action == grl_pkg::ACT_COMPUTE) && idx_ok_comp) begin
					state_nx = idx_last ? grl_pkg::ST_RD0 : grl_pkg::ST_P_MUL;
				end
			end
			grl_pkg::ST_P_MUL: begin
				mul_a    = {{(DW+1-IW){1'b0}}, idx_q} + (DW+1)'(pick_q ? 0 : 1);
				mul_b    = {1'b0, sm1};
				state_nx = grl_pkg::ST_P_DIV;
			end
			grl_pkg::ST_P_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q[DW-1:0] - DW'(pick_q ? 0 : 1);
				div_req.divisor  = tm1;
				state_nx         = grl_pkg::ST_P_WAIT;
			end
			grl_pkg::ST_P_WAIT: begin
				if (div_rsp.done) begin
					state_nx = pick_q ? grl_pkg::ST_RD0 : grl_pkg::ST_Q_MUL;
				end
			end
			grl_pkg::ST_Q_MUL: begin
				mul_a    = {{(DW+1-CW){1'b0}}, p_q};
				mul_b    = {1'b0, tm1};
				state_nx = grl_pkg::ST_Q_DIV;
			end
			grl_pkg::ST_Q_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q[DW-1:0];
				div_req.divisor  = sm1;
				state_nx         = grl_pkg::ST_Q_WAIT;
			end
			grl_pkg::ST_Q_WAIT: begin
				if (div_rsp.done) begin
					state_nx = grl_pkg::ST_R_MUL;
				end
			end
			grl_pkg::ST_R_MUL: begin
				mul_a    = {{(DW+1-CW){1'b0}}, p_q + CW'(1)};
				mul_b    = {1'b0, tm1};
				state_nx = grl_pkg::ST_R_DIV;
			end
			grl_pkg::ST_R_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q[DW-1:0];
				div_req.divisor  = sm1;
				state_nx         = grl_pkg::ST_R_WAIT;
			end
			grl_pkg::ST_R_WAIT: begin
				if (div_rsp.done) begin
					state_nx = grl_pkg::ST_WEIGHT;
				end
			end
			grl_pkg::ST_WEIGHT: state_nx = grl_pkg::ST_RD0;
			grl_pkg::ST_RD0: begin
				ram_raddr = p_ext[AW-1:0];
				state_nx  = grl_pkg::ST_RD1;
			end
			grl_pkg::ST_RD1: begin
				ram_raddr = p1_ext[AW-1:0];
				state_nx  = pick_q ? grl_pkg::ST_IDLE : grl_pkg::ST_RD2;
			end
			grl_pkg::ST_RD2: state_nx = grl_pkg::ST_F_MUL0;
			grl_pkg::ST_F_MUL0: begin
				mul_a    = {v0_q[f_q][DW-1], v0_q[f_q]};
				mul_b    = wa_q;
				state_nx = grl_pkg::ST_F_MUL1;
			end
			grl_pkg::ST_F_MUL1: begin
				mul_a    = {v1_q[f_q][DW-1], v1_q[f_q]};
				mul_b    = wb_q;
				state_nx = grl_pkg::ST_F_ADD;
			end
			grl_pkg::ST_F_ADD: state_nx = grl_pkg::ST_F_ABS;
			grl_pkg::ST_F_ABS: state_nx = grl_pkg::ST_F_DIV;
			grl_pkg::ST_F_DIV: begin
				// high part of the magnitude is below the span, so it seeds the remainder
				div_req.start    = 1'b1;
				div_req.rem_init = mag_q[DW +: CW];
				div_req.dividend = mag_q[DW-1:0];
				div_req.divisor  = c_q;
				state_nx         = grl_pkg::ST_F_WAIT;
			end
			grl_pkg::ST_F_WAIT: begin
				if (div_rsp.done) begin
					state_nx = (f_q == 2'(NF - 1)) ? grl_pkg::ST_IDLE : grl_pkg::ST_F_MUL0;
				end
			end
			default: state_nx = grl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			f_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept && !((action == grl_pkg::ACT_COMPUTE) && idx_ok_comp)) begin
				done_q <= 1'b1;
			end
			if (state_q == grl_pkg::ST_RD1 && pick_q) begin
				done_q <= 1'b1;
			end
			if (state_q == grl_pkg::ST_RD2) begin
				f_q <= '0;
			end
			if (state_q == grl_pkg::ST_F_WAIT && div_rsp.done) begin
				f_q <= f_q + 2'(1);
				if (f_q == 2'(NF - 1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod;
		if (accept) begin
			idx_q <= point_index;
			pick_q <= idx_last || (t_cl <= s_cl);
			p_q    <= sm1;
			res_q  <= '0;
			if (action == grl_pkg::ACT_STORE) begin
				status_q <= idx_ok_store ? grl_pkg::STATUS_STORED : grl_pkg::STATUS_RANGE;
			end else begin
				status_q <= idx_ok_comp ? grl_pkg::STATUS_COMPUTED : grl_pkg::STATUS_RANGE;
			end
		end
		unique case (state_q)
			grl_pkg::ST_P_WAIT: if (div_rsp.done) p_q <= div_rsp.quotient[CW-1:0];
			grl_pkg::ST_Q_WAIT: if (div_rsp.done) qi_q <= div_rsp.quotient[CW-1:0];
			grl_pkg::ST_R_WAIT: if (div_rsp.done) ri_q <= div_rsp.quotient[CW-1:0];
			grl_pkg::ST_WEIGHT: begin
				wa_q <= $signed({1'b0, ri_q}) - $signed({{(CW+1-IW){1'b0}}, idx_q});
				wb_q <= $signed({{(CW+1-IW){1'b0}}, idx_q}) - $signed({1'b0, qi_q});
				c_q  <= (c_raw <= 0) ? CW'(1) : c_raw[CW-1:0];
			end
			grl_pkg::ST_RD1: begin
				v0_q <= ram_rdata;
				if (pick_q) begin
					res_q <= ram_rdata;
				end
			end
			grl_pkg::ST_RD2:    v1_q <= ram_rdata;
			grl_pkg::ST_F_MUL1: acc_q <= mul_q;
			grl_pkg::ST_F_ADD:  num_q <= acc_q + mul_q;
			grl_pkg::ST_F_ABS: begin
				neg_q <= num_q[PROD_W-1];
				mag_q <= num_q[PROD_W-1] ? MAG_W'(-num_q) : num_q[MAG_W-1:0];
			end
			grl_pkg::ST_F_WAIT: if (div_rsp.done) res_q[f_q] <= quot_s;
			default: ;
		endcase
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_a     = res_q[0];
	assign out_delta = res_q[1];
	assign out_phi   = res_q[2];
	assign out_pi    = res_q[3];

`ifndef SYNTHESIS
	a_zero_unless_computed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != grl_pkg::STATUS_COMPUTED) |->
		(out_a == 0 && out_delta == 0 && out_phi == 0 && out_pi == 0))
		else $error("nonzero value fields on a store or range result");

	a_div_free_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while still running");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == grl_pkg::ST_P_WAIT || state_q == grl_pkg::ST_Q_WAIT ||
		state_q == grl_pkg::ST_R_WAIT || state_q == grl_pkg::ST_F_WAIT))
		else $error("quotient arrived with no sequencer step waiting for it");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grl_pkg::ST_F_DIV) |-> (c_q != 0 && wa_q >= 0 && wb_q >= 0))
		else $error("interpolation span or weights out of range");

	a_compute_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == grl_pkg::STATUS_COMPUTED) |-> !busy)
		else $error("computed result shown while sequencer still running");
`endif

endmodule

// ===== sim/grid_resample_linear_core_test.sv =====
`timescale 1ns / 1ps

module grid_resample_linear_core_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 90;
	localparam int FIXED_PHASES = 13;

	localparam logic [127:0] NO_VALS = '0;
	localparam logic [127:0] HIGH_VALS = {32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF};
	localparam logic [127:0] LOW_VALS = {32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000001};
	localparam logic [127:0] CHECKER_VALS = {32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555};
	localparam logic [127:0] UNIT_VALS = {32'h00010000, 32'hFFFF0000, 32'h00008000, 32'hFFFF8000};
	localparam logic [129:0] PREDICTED = '0;

	// raw register values, out-of-range ones included to exercise clamping
	localparam logic [0:FIXED_PHASES-1][10:0] PHASE_SRC = {11'd1024, 11'd2, 11'd1024, 11'd0,
		11'd1, 11'd2047, 11'd5, 11'd37, 11'd13, 11'd3, 11'd100, 11'd2, 11'd640};
	localparam logic [0:FIXED_PHASES-1][10:0] PHASE_TGT = {11'd2, 11'd2, 11'd1024, 11'd2047,
		11'd1, 11'd3, 11'd37, 11'd5, 11'd13, 11'd1000, 11'd7, 11'd1024, 11'd777};

	typedef struct packed {
		logic             act;
		logic [9:0]       idx;
		logic [0:3][31:0] vals;
	} point_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [0:3][31:0] vals;
	} point_result_t;

	typedef struct packed {
		point_item_t   item;
		logic          typed;
		point_result_t want;
	} directed_row_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [2:0]                paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      action = 1'b0;
	logic [grl_pkg::IDX_W-1:0] point_index = '0;
	logic signed [31:0]        in_a = '0;
	logic signed [31:0]        in_delta = '0;
	logic signed [31:0]        in_phi = '0;
	logic signed [31:0]        in_pi = '0;
	logic                      done;
	logic [1:0]                status;
	logic signed [31:0]        out_a;
	logic signed [31:0]        out_delta;
	logic signed [31:0]        out_phi;
	logic signed [31:0]        out_pi;

	logic [31:0]   source_vals [4][1024];
	bit            source_written [1024];
	logic [10:0]   cfg_src = 11'd2;
	logic [10:0]   cfg_tgt = 11'd1024;
	point_result_t pending_results [$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            calm_left = 0;
	string         field_names [5] = '{"status", "out_a", "out_delta", "out_phi", "out_pi"};

	// reset config is S=2, T=1024: computes interpolate between points 0 and 1
	directed_row_t directed_rows [18] = '{
		{grl_pkg::ACT_STORE, 10'd2, HIGH_VALS, 1'b1, grl_pkg::STATUS_RANGE, NO_VALS},
		{grl_pkg::ACT_STORE, 10'd1023, LOW_VALS, 1'b1, grl_pkg::STATUS_RANGE, NO_VALS},
		{grl_pkg::ACT_STORE, 10'd0, HIGH_VALS, 1'b1, grl_pkg::STATUS_STORED, NO_VALS},
		{grl_pkg::ACT_STORE, 10'd1, LOW_VALS, 1'b1, grl_pkg::STATUS_STORED, NO_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd0, NO_VALS, 1'b1, grl_pkg::STATUS_COMPUTED, HIGH_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd1023, HIGH_VALS, 1'b1, grl_pkg::STATUS_COMPUTED, LOW_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd511, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_COMPUTE, 10'd512, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_COMPUTE, 10'd1, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_COMPUTE, 10'd1022, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_STORE, 10'd1, CHECKER_VALS, 1'b1, grl_pkg::STATUS_STORED, NO_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd1023, NO_VALS, 1'b1, grl_pkg::STATUS_COMPUTED,
			CHECKER_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd341, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_STORE, 10'd0, UNIT_VALS, 1'b1, grl_pkg::STATUS_STORED, NO_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd682, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_COMPUTE, 10'd0, NO_VALS, 1'b1, grl_pkg::STATUS_COMPUTED, UNIT_VALS},
		{grl_pkg::ACT_COMPUTE, 10'd3, NO_VALS, 1'b0, PREDICTED},
		{grl_pkg::ACT_STORE, 10'd1000, CHECKER_VALS, 1'b1, grl_pkg::STATUS_RANGE, NO_VALS}
	};

	grid_resample_linear_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.point_index (point_index),
		.in_a        (in_a),
		.in_delta    (in_delta),
		.in_phi      (in_phi),
		.in_pi       (in_pi),
		.done        (done),
		.status      (status),
		.out_a       (out_a),
		.out_delta   (out_delta),
		.out_phi     (out_phi),
		.out_pi      (out_pi)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_points(logic [10:0] n);
		if (n < 11'd2) return 2;
		if (n > 11'd1024) return 1024;
		return int'(n);
	endfunction

	// Find the source point a target index reads; pair means it also reads p+1.
	function automatic void locate_source(int idx, int s, int t, output int p, output bit pair);
		pair = 1'b0;
		if (idx == t - 1) begin
			p = s - 1;
		end else if (t <= s) begin
			p = idx * (s - 1) / (t - 1);
		end else begin
			p = ((idx + 1) * (s - 1) - 1) / (t - 1);
			if (p > s - 2) p = s - 2;
			pair = 1'b1;
		end
	endfunction

	function automatic point_result_t resample_point(point_item_t it);
		point_result_t res;
		int            s, t, idx, p, q, r, c;
		bit            pair;
		longint        lo, hi, num;
		s = clamp_points(cfg_src);
		t = clamp_points(cfg_tgt);
		idx = int'(it.idx);
		res = '0;
		if (it.act == grl_pkg::ACT_STORE) begin
			if (idx >= s) begin
				res.status = grl_pkg::STATUS_RANGE;
			end else begin
				res.status = grl_pkg::STATUS_STORED;
				for (int f = 0; f < 4; f++) source_vals[f][idx] = it.vals[f];
				source_written[idx] = 1'b1;
			end
		end else if (idx >= t) begin
			res.status = grl_pkg::STATUS_RANGE;
		end else begin
			res.status = grl_pkg::STATUS_COMPUTED;
			locate_source(idx, s, t, p, pair);
			if (!pair) begin
				for (int f = 0; f < 4; f++) res.vals[f] = source_vals[f][p];
			end else begin
				q = p * (t - 1) / (s - 1);
				r = (p + 1) * (t - 1) / (s - 1);
				c = r - q;
				if (c <= 0) c = 1;
				for (int f = 0; f < 4; f++) begin
					lo = longint'($signed(source_vals[f][p]));
					hi = longint'($signed(source_vals[f][p + 1]));
					num = (lo * (r - idx) + hi * (idx - q)) / c;
					res.vals[f] = num[31:0];
				end
			end
		end
		return res;
	endfunction

	// Mostly in-range computes; a compute that would read an unstored point
	// turns into the store of that point instead.
	function automatic point_item_t draw_item();
		point_item_t it;
		int          s, t, k, p;
		bit          pair;
		s = clamp_points(cfg_src);
		t = clamp_points(cfg_tgt);
		for (int f = 0; f < 4; f++) begin
			case ($urandom_range(0, 7))
				0: it.vals[f] = 32'h7FFFFFFF;
				1: it.vals[f] = 32'h80000000;
				2: it.vals[f] = 32'h00000000;
				3: it.vals[f] = 32'hFFFFFFFF;
				default: it.vals[f] = $urandom;
			endcase
		end
		k = $urandom_range(0, 99);
		if (k < 55) begin
			it.act = grl_pkg::ACT_COMPUTE;
			it.idx = ($urandom_range(0, 9) == 0) ? 10'(t - 1) : 10'($urandom_range(0, t - 1));
		end else if (k < 75) begin
			it.act = grl_pkg::ACT_STORE;
			it.idx = 10'($urandom_range(0, s - 1));
		end else if (k < 83) begin
			it.act = grl_pkg::ACT_STORE;
			it.idx = (s < 1024) ? 10'($urandom_range(s, 1023)) : 10'($urandom_range(0, 1023));
		end else if (k < 91) begin
			it.act = grl_pkg::ACT_COMPUTE;
			it.idx = (t < 1024) ? 10'($urandom_range(t, 1023)) : 10'($urandom_range(0, 1023));
		end else begin
			it.act = 1'($urandom_range(0, 1));
			it.idx = 10'($urandom_range(0, 1023));
		end
		if (it.act == grl_pkg::ACT_COMPUTE && int'(it.idx) < t) begin
			locate_source(int'(it.idx), s, t, p, pair);
			if (!source_written[p]) begin
				it.act = grl_pkg::ACT_STORE;
				it.idx = 10'(p);
			end else if (pair && !source_written[p + 1]) begin
				it.act = grl_pkg::ACT_STORE;
				it.idx = 10'(p + 1);
			end
		end
		return it;
	endfunction

	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_item(point_item_t it, logic typed, point_result_t typed_res);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
			gap = $urandom_range(0, 19);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= it.act;
		point_index <= it.idx;
		in_a <= it.vals[0];
		in_delta <= it.vals[1];
		in_phi <= it.vals[2];
		in_pi <= it.vals[3];
		do @(posedge clk); while (busy !== 1'b0);
		if (typed) begin
			void'(resample_point(it));
			pending_results.push_back(typed_res);
		end else begin
			pending_results.push_back(resample_point(it));
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(logic reg_sel, logic [10:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {21'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == grl_pkg::REG_SOURCE_POINTS) cfg_src = value;
		else cfg_tgt = value;
		@(posedge clk);
	endtask

	task automatic run_phase(logic [10:0] src_raw, logic [10:0] tgt_raw);
		drain_results();
		write_register(grl_pkg::REG_SOURCE_POINTS, src_raw);
		write_register(grl_pkg::REG_TARGET_POINTS, tgt_raw);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// hold off now and then until the block has answered everything
			if ($urandom_range(0, 49) == 0) drain_results();
			send_item(draw_item(), 1'b0, '0);
		end
	endtask

	task automatic count_failure(string text);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%t: %s", $realtime, text);
	endtask

	always @(posedge clk) begin : result_check
		point_result_t want;
		logic [31:0]   got_f [5];
		logic [31:0]   want_f [5];
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				count_failure($sformatf("result with no transaction pending, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				got_f = '{{30'd0, status}, out_a, out_delta, out_phi, out_pi};
				want_f = '{{30'd0, want.status}, want.vals[0], want.vals[1],
					want.vals[2], want.vals[3]};
				for (int f = 0; f < 5; f++) begin
					if (got_f[f] !== want_f[f])
						count_failure($sformatf("%s: expected %h, got %h",
							field_names[f], want_f[f], got_f[f]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** grid_resample_linear_core: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		for (int i = 0; i < FIXED_PHASES; i++) run_phase(PHASE_SRC[i], PHASE_TGT[i]);
		run_phase(11'($urandom_range(2, 64)), 11'($urandom_range(2, 64)));
		run_phase(11'($urandom_range(2, 64)), 11'($urandom_range(2, 1024)));
		run_phase(11'($urandom_range(2, 1024)), 11'($urandom_range(2, 64)));
		drain_results();
		repeat (120) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("** grid_resample_linear_core: PASSED **");
		end else begin
			$display("** grid_resample_linear_core: FAILED **");
		end
		$finish;
	end

endmodule
